>>> sv/tagged_measurement_frame_parser_defines.svh
// ---------------------------------------------------------------------------
// tagged measurement frame parser assertion macros
// shared concurrent assertion forms for the checker
// ---------------------------------------------------------------------------
`ifndef TAGGED_MEASUREMENT_FRAME_PARSER_DEFINES_SVH
`define TAGGED_MEASUREMENT_FRAME_PARSER_DEFINES_SVH

// antecedent implies consequent in the same cycle, masked during reset
`define TMFP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tmfp assertion failed");

// antecedent implies consequent in the next cycle, masked during reset
`define TMFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tmfp assertion failed");

// antecedent implies consequent in the next cycle, checked through reset
`define TMFP_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tmfp reset assertion failed");

`endif

>>> sv/tmfp_pkg.sv
// ---------------------------------------------------------------------------
// tmfp_pkg
// shared constants for the tagged measurement frame parser
// ---------------------------------------------------------------------------
package tmfp_pkg;

  // default data bytes per segment
  localparam int unsigned FIELD_BYTES_DEF = 4;

  // segment tags
  localparam logic [7:0] TAG_SUPPLY  = 8'h61;
  localparam logic [7:0] TAG_OUTPUT  = 8'h62;
  localparam logic [7:0] TAG_CURRENT = 8'h63;

  // field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CFG_W  = 17;
  localparam int unsigned VOLT_W = 16;
  localparam int unsigned CUR_W  = 32;

  // voltage limit after reset, in hundredths
  localparam logic [CFG_W-1:0] LIMIT_RESET = 17'd1100;

  // compare width and the bound set by the 16-bit held voltages
  localparam int unsigned CMP_W     = 33;
  localparam int unsigned VOLT_SPAN = 1 << VOLT_W;

endpackage

>>> sv/tmfp_frame_check.sv
// ---------------------------------------------------------------------------
// tmfp_frame_check
// frame acceptance: clean tags and both voltages below 65536 and inside (0, limit)
// ---------------------------------------------------------------------------
module tmfp_frame_check #(
  parameter int unsigned ACC_W = 8 * tmfp_pkg::FIELD_BYTES_DEF
) (
  input  logic [ACC_W-1:0]            supply,
  input  logic [ACC_W-1:0]            outv,
  input  logic [tmfp_pkg::CFG_W-1:0]  limit,
  input  logic                        tag_err,
  output logic                        ok
);

  logic supply_ok;
  logic output_ok;

  // strict bounds, also capped by what 16 bits can hold
  always_comb begin
    supply_ok = (supply != '0)
             && (tmfp_pkg::CMP_W'(supply) < tmfp_pkg::CMP_W'(limit))
             && (tmfp_pkg::CMP_W'(supply) < tmfp_pkg::CMP_W'(tmfp_pkg::VOLT_SPAN));
    output_ok = (outv != '0)
             && (tmfp_pkg::CMP_W'(outv) < tmfp_pkg::CMP_W'(limit))
             && (tmfp_pkg::CMP_W'(outv) < tmfp_pkg::CMP_W'(tmfp_pkg::VOLT_SPAN));
    ok = !tag_err && supply_ok && output_ok;
  end

endmodule

>>> sv/tagged_measurement_frame_parser.sv
// ---------------------------------------------------------------------------
// tagged measurement frame parser
// parses 3-segment tagged frames of received bytes into held measurements
// ---------------------------------------------------------------------------
// usage
//   in_valid / in_ready / in_rx_byte carry one received byte per word.
//   a frame is 'a' + supply, 'b' + output, 'c' + current, each value sent
//   FIELD_BYTES bytes most significant first (15 bytes at the default).
//   out_valid / out_ready deliver one word per frame end with the held
//   values, accepted and tag_error.
//   cfg_wr_en / cfg_wr_data write voltage_limit; write only while idle.
// timing
//   a byte is taken into an input register, then processed from there
//   by a compare and shift; the result word is registered in the output
//   register when the last byte of a frame is processed. one byte per
//   cycle is sustained; the single output register lets the block keep
//   taking bytes while a result waits, and only a frame end that meets a
//   full output register stalls the input.
// reset
//   synchronous active-low reset clears the frame position, pending and
//   held values and both registers' valid flags; the limit returns to 1100.
// ---------------------------------------------------------------------------
module tagged_measurement_frame_parser #(
  parameter int unsigned FIELD_BYTES = tmfp_pkg::FIELD_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [tmfp_pkg::BYTE_W-1:0]        in_rx_byte,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [tmfp_pkg::VOLT_W-1:0]        out_supply_voltage,
  output logic [tmfp_pkg::VOLT_W-1:0]        out_output_voltage,
  output logic signed [tmfp_pkg::CUR_W-1:0]  out_load_current,
  output logic                               out_accepted,
  output logic                               out_tag_error,
  input  logic                               cfg_wr_en,
  input  logic [tmfp_pkg::CFG_W-1:0]         cfg_wr_data
);

  localparam int unsigned ACC_W = 8 * FIELD_BYTES;
  localparam int unsigned OFF_W = $clog2(FIELD_BYTES + 1);
  localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(FIELD_BYTES);
  localparam logic [1:0] SEG_SUPPLY  = 2'd0;
  localparam logic [1:0] SEG_OUTPUT  = 2'd1;
  localparam logic [1:0] SEG_CURRENT = 2'd2;

  // input register
  logic                        in_valid_r;
  logic [tmfp_pkg::BYTE_W-1:0] in_byte_r;

  // frame state
  logic [1:0]       seg_r, seg_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [ACC_W-1:0] pend_supply_r, pend_supply_nxt;
  logic [ACC_W-1:0] pend_output_r, pend_output_nxt;
  logic             err_r, err_nxt;
  logic [tmfp_pkg::VOLT_W-1:0] held_supply_r, held_supply_nxt;
  logic [tmfp_pkg::VOLT_W-1:0] held_output_r, held_output_nxt;
  logic [tmfp_pkg::CUR_W-1:0]  held_current_r, held_current_nxt;

  // configuration
  logic [tmfp_pkg::CFG_W-1:0] limit_r;

  // output register
  logic                        out_valid_r;
  logic [tmfp_pkg::VOLT_W-1:0] out_supply_r;
  logic [tmfp_pkg::VOLT_W-1:0] out_output_r;
  logic [tmfp_pkg::CUR_W-1:0]  out_current_r;
  logic                        out_accepted_r;
  logic                        out_tag_err_r;

  logic                        frame_end;
  logic                        proc_fire;
  logic                        frame_ok;
  logic                        tag_bad;
  logic [7:0]                  tag_exp;
  logic [ACC_W+7:0]            acc_shift;

  // the byte in the input register closes a frame
  assign frame_end = (seg_r == SEG_CURRENT) && (off_r == OFF_LAST);

  // process the held byte unless it closes a frame into a full output
  assign proc_fire = in_valid_r && (!frame_end || !out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || proc_fire;

  // expected tag for the current segment
  always_comb begin
    unique case (seg_r)
      SEG_SUPPLY:  tag_exp = tmfp_pkg::TAG_SUPPLY;
      SEG_OUTPUT:  tag_exp = tmfp_pkg::TAG_OUTPUT;
      SEG_CURRENT: tag_exp = tmfp_pkg::TAG_CURRENT;
      default:     tag_exp = tmfp_pkg::TAG_CURRENT;
    endcase
  end

  assign tag_bad   = (in_byte_r != tag_exp);
  assign acc_shift = {acc_r, in_byte_r};

  // per-byte state update
  always_comb begin
    seg_nxt         = seg_r;
    off_nxt         = off_r;
    acc_nxt         = acc_r;
    pend_supply_nxt = pend_supply_r;
    pend_output_nxt = pend_output_r;
    err_nxt         = err_r;
    if (off_r == '0) begin
      acc_nxt = '0;
      err_nxt = (seg_r == SEG_SUPPLY) ? tag_bad : (err_r | tag_bad);
    end else begin
      acc_nxt = acc_shift[ACC_W-1:0];
      if (off_r == OFF_LAST) begin
        if (seg_r == SEG_SUPPLY) pend_supply_nxt = acc_nxt;
        if (seg_r == SEG_OUTPUT) pend_output_nxt = acc_nxt;
      end
    end
    // advance position
    if (off_r == OFF_LAST) begin
      off_nxt = '0;
      seg_nxt = frame_end ? SEG_SUPPLY : seg_r + 2'd1;
    end else begin
      off_nxt = off_r + OFF_W'(1);
    end
  end

  tmfp_frame_check #(
    .ACC_W (ACC_W)
  ) u_check (
    .supply  (pend_supply_r),
    .outv    (pend_output_r),
    .limit   (limit_r),
    .tag_err (err_r),
    .ok      (frame_ok)
  );

  // held values take the frame when it passes
  always_comb begin
    held_supply_nxt  = held_supply_r;
    held_output_nxt  = held_output_r;
    held_current_nxt = held_current_r;
    if (frame_end && frame_ok) begin
      held_supply_nxt  = tmfp_pkg::VOLT_W'(pend_supply_r);
      held_output_nxt  = tmfp_pkg::VOLT_W'(pend_output_r);
      held_current_nxt = tmfp_pkg::CUR_W'(acc_nxt);
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
  end

  // frame state and held values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r          <= SEG_SUPPLY;
      off_r          <= '0;
      acc_r          <= '0;
      pend_supply_r  <= '0;
      pend_output_r  <= '0;
      err_r          <= 1'b0;
      held_supply_r  <= '0;
      held_output_r  <= '0;
      held_current_r <= '0;
    end else if (proc_fire) begin
      seg_r          <= seg_nxt;
      off_r          <= off_nxt;
      acc_r          <= acc_nxt;
      pend_supply_r  <= pend_supply_nxt;
      pend_output_r  <= pend_output_nxt;
      err_r          <= err_nxt;
      held_supply_r  <= held_supply_nxt;
      held_output_r  <= held_output_nxt;
      held_current_r <= held_current_nxt;
    end
  end

  // voltage limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= tmfp_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_fire && frame_end) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (proc_fire && frame_end) begin
      out_supply_r   <= held_supply_nxt;
      out_output_r   <= held_output_nxt;
      out_current_r  <= held_current_nxt;
      out_accepted_r <= frame_ok;
      out_tag_err_r  <= err_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_supply_voltage = out_supply_r;
  assign out_output_voltage = out_output_r;
  assign out_load_current   = out_current_r;
  assign out_accepted       = out_accepted_r;
  assign out_tag_error      = out_tag_err_r;

endmodule

>>> sv/tmfp_checker.sv
// ---------------------------------------------------------------------------
// tmfp_checker
// port-level checks for the tagged measurement frame parser
// ---------------------------------------------------------------------------
`include "tagged_measurement_frame_parser_defines.svh"

module tmfp_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [tmfp_pkg::VOLT_W-1:0]        out_supply_voltage,
  input logic [tmfp_pkg::VOLT_W-1:0]        out_output_voltage,
  input logic signed [tmfp_pkg::CUR_W-1:0]  out_load_current,
  input logic                               out_accepted,
  input logic                               out_tag_error
);

  // a stalled result word holds
  `TMFP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_supply_voltage) && $stable(out_output_voltage) && $stable(out_load_current))

  // an accepted frame never carries a tag error
  `TMFP_ASSERT_NOW(a_acc_no_err, clk, rst_n, out_valid && out_accepted, !out_tag_error)

  // an accepted frame holds nonzero voltages
  `TMFP_ASSERT_NOW(a_acc_nonzero, clk, rst_n, out_valid && out_accepted, out_supply_voltage != 0 && out_output_voltage != 0)

  // with an empty output register the input is always open
  `TMFP_ASSERT_NOW(a_in_open, clk, rst_n, !out_valid, in_ready)

  // no result word right after reset
  `TMFP_ASSERT_NEXT_ALWAYS(a_reset_idle, clk, !rst_n, !out_valid)

endmodule

bind tagged_measurement_frame_parser tmfp_checker u_tmfp_checker (.*);
